[rtl/msplm_pkg.sv]
// shared types, constants and arithmetic helpers for the pan-law mixer
// used by the controller, the datapath and the divider; no dependencies
package msplm_pkg;

  // fixed formats of the sample path and the gain path
  localparam int SAMPLE_W    = 24;
  localparam int POS_W       = 17;
  localparam int GAIN_W      = 17;
  localparam int STEP_W      = 18;
  localparam int COEFF_W     = 18;
  localparam int FRAMES_W    = 14;
  localparam int RL_W        = 7;
  localparam int EFF_W       = 19;
  localparam int MUL_A_W     = 25;
  localparam int MUL_B_W     = 21;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RND_W       = 30;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 1;

  localparam int ONE_Q16     = 65536;
  localparam int LAW_A       = 54512;
  localparam int SMOOTH_Q16  = 58982;
  localparam int THRESH      = 131;
  localparam int GAIN_MAX    = 131071;
  localparam int CENTER_GAIN = 46396;
  localparam int RAMP_LEN    = 64;
  localparam int POS_RESET   = 32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAN_POSITION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTOMATION     = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LAW1_L,
    OP_LAW1_R,
    OP_LAW2_L,
    OP_LAW2_R,
    OP_ADV_L,
    OP_ADV_R,
    OP_EFF_L,
    OP_EFF_R,
    OP_OUT_L,
    OP_OUT_R
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAW,
    ST_DIVL_GO,
    ST_DIVL_WAIT,
    ST_DIVR_GO,
    ST_DIVR_WAIT,
    ST_ADV,
    ST_EFF,
    ST_OUT,
    ST_WB,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic    capture;
    mul_op_e op;
    logic    div_start;
    logic    div_sel;    // 0 left, 1 right
    logic    blk_l;
    logic    blk_r;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic auto_mode;
    logic block_start;
    logic div_busy;
  } dp_status_t;

  // round to nearest, halves away from zero, then drop 16 fraction bits
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W:0] s;
    s = {v[PROD_W-1], v} + (PROD_W+1)'(32767) + {{PROD_W{1'b0}}, ~v[PROD_W-1]};
    return s[RND_W+15:16];
  endfunction

  // clamp a ramp value into the gain range
  function automatic logic [GAIN_W-1:0] clamp_gain(input logic signed [21:0] v);
    logic [GAIN_W-1:0] r;
    if (v[21]) begin
      r = '0;
    end else if (|v[20:GAIN_W]) begin
      r = GAIN_W'(GAIN_MAX);
    end else begin
      r = v[GAIN_W-1:0];
    end
    return r;
  endfunction

  // saturate a mix sum to the sample width
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [30:0] v);
    logic [SAMPLE_W-1:0] r;
    if ((&v[30:SAMPLE_W-1]) || !(|v[30:SAMPLE_W-1])) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[30]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // positions above full scale saturate to full scale
  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
    return (p > POS_W'(ONE_Q16)) ? POS_W'(ONE_Q16) : p;
  endfunction

endpackage

[rtl/msplm_div.sv]
// restoring divider for the ramp step, one quotient bit per cycle
// depends on msplm_pkg
module msplm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [msplm_pkg::STEP_W-1:0] dividend_i,
  input  logic [msplm_pkg::RL_W-1:0]        divisor_i,
  output logic                              busy_o,
  output logic signed [msplm_pkg::STEP_W-1:0] quot_o
);

  localparam int W = msplm_pkg::STEP_W;
  localparam int DW = msplm_pkg::RL_W;

  logic [4:0]    cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_q, num_q[W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    neg_d = neg_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = 5'(W);
      neg_d = dividend_i[W-1];
      num_d = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      num_d = {num_q[W-2:0], fits};
      rem_d = fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != 5'd0;
  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

[rtl/msplm_ctrl.sv]
// sequencer for the pan-law mixer: handshake, multiplier op order, output slot
// depends on msplm_pkg
module msplm_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  msplm_pkg::dp_status_t   status_i,
  output msplm_pkg::ctrl_cmd_t    cmd_o
);

  msplm_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msplm_pkg::ST_IDLE;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    out_valid_d     = out_valid_q && out_stall_i;
    cmd_o.capture   = 1'b0;
    cmd_o.op        = msplm_pkg::OP_NONE;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = 1'b0;
    cmd_o.blk_l     = 1'b0;
    cmd_o.blk_r     = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      msplm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = msplm_pkg::ST_PREP;
        end
      end
      msplm_pkg::ST_PREP: begin
        cnt_d = 2'd0;
        if (status_i.auto_mode || status_i.block_start) begin
          state_d = msplm_pkg::ST_LAW;
        end else begin
          state_d = msplm_pkg::ST_ADV;
        end
      end
      msplm_pkg::ST_LAW: begin
        case (cnt_q)
          2'd0:    cmd_o.op = msplm_pkg::OP_LAW1_L;
          2'd1:    cmd_o.op = msplm_pkg::OP_LAW1_R;
          2'd2:    cmd_o.op = msplm_pkg::OP_LAW2_L;
          default: cmd_o.op = msplm_pkg::OP_LAW2_R;
        endcase
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = status_i.auto_mode ? msplm_pkg::ST_OUT : msplm_pkg::ST_DIVL_GO;
        end
      end
      msplm_pkg::ST_DIVL_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b0;
        state_d         = msplm_pkg::ST_DIVL_WAIT;
      end
      msplm_pkg::ST_DIVL_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.blk_l = 1'b1;
          state_d     = msplm_pkg::ST_DIVR_GO;
        end
      end
      msplm_pkg::ST_DIVR_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = msplm_pkg::ST_DIVR_WAIT;
      end
      msplm_pkg::ST_DIVR_WAIT: begin
        cmd_o.div_sel = 1'b1;
        if (!status_i.div_busy) begin
          cmd_o.blk_r = 1'b1;
          cnt_d       = 2'd0;
          state_d     = msplm_pkg::ST_ADV;
        end
      end
      msplm_pkg::ST_ADV: begin
        cmd_o.op = cnt_q[0] ? msplm_pkg::OP_ADV_R : msplm_pkg::OP_ADV_L;
        cnt_d    = {1'b0, ~cnt_q[0]};
        if (cnt_q[0]) begin
          state_d = msplm_pkg::ST_EFF;
        end
      end
      msplm_pkg::ST_EFF: begin
        cmd_o.op = cnt_q[0] ? msplm_pkg::OP_EFF_R : msplm_pkg::OP_EFF_L;
        cnt_d    = {1'b0, ~cnt_q[0]};
        if (cnt_q[0]) begin
          state_d = msplm_pkg::ST_OUT;
        end
      end
      msplm_pkg::ST_OUT: begin
        cmd_o.op = cnt_q[0] ? msplm_pkg::OP_OUT_R : msplm_pkg::OP_OUT_L;
        cnt_d    = {1'b0, ~cnt_q[0]};
        if (cnt_q[0]) begin
          state_d = msplm_pkg::ST_WB;
        end
      end
      msplm_pkg::ST_WB: begin
        // right result lands in this cycle
        state_d = msplm_pkg::ST_LOAD;
      end
      msplm_pkg::ST_LOAD: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = msplm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msplm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = state_q != msplm_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/msplm_dpath.sv]
// datapath of the pan-law mixer: config, gain state, shared multiplier, output regs
// depends on msplm_pkg and msplm_div
module msplm_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [msplm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msplm_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0]  left_mix_in_i,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0]  right_mix_in_i,
  input  logic                                   block_start_i,
  input  logic [msplm_pkg::FRAMES_W-1:0]         block_frames_i,
  input  logic [msplm_pkg::COEFF_W-1:0]          gain_coeff_i,
  input  logic [msplm_pkg::POS_W-1:0]            automation_position_i,
  input  msplm_pkg::ctrl_cmd_t                   cmd_i,
  output msplm_pkg::dp_status_t                  status_o,
  output logic signed [msplm_pkg::SAMPLE_W-1:0]  left_out_o,
  output logic signed [msplm_pkg::SAMPLE_W-1:0]  right_out_o
);

  localparam int SW = msplm_pkg::SAMPLE_W;
  localparam int GW = msplm_pkg::GAIN_W;
  localparam int PW = msplm_pkg::POS_W;
  localparam int TW = msplm_pkg::STEP_W;
  localparam int RW = msplm_pkg::RL_W;
  localparam int EW = msplm_pkg::EFF_W;

  // configuration
  logic [PW-1:0] pan_q;
  logic          auto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q  <= PW'(msplm_pkg::POS_RESET);
      auto_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == msplm_pkg::REG_PAN_POSITION) begin
        pan_q <= msplm_pkg::clamp_pos(cfg_wdata_i[PW-1:0]);
      end else if (cfg_index_i == msplm_pkg::REG_AUTOMATION) begin
        auto_q <= cfg_wdata_i[0];
      end
    end
  end

  // captured transaction
  logic signed [SW-1:0]            smp_q, lmix_q, rmix_q;
  logic                            blk_q;
  logic [msplm_pkg::FRAMES_W-1:0]  frames_q;
  logic [msplm_pkg::COEFF_W-1:0]   coeff_q;
  logic [PW-1:0]                   apos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q    <= sample_in_i;
      lmix_q   <= left_mix_in_i;
      rmix_q   <= right_mix_in_i;
      blk_q    <= block_start_i;
      frames_q <= block_frames_i;
      coeff_q  <= gain_coeff_i;
      apos_q   <= automation_position_i;
    end
  end

  // gain state, per channel
  logic [GW-1:0]        g_l_q, g_l_d, iv_l_q, iv_l_d, g_r_q, g_r_d, iv_r_q, iv_r_d;
  logic signed [TW-1:0] st_l_q, st_l_d, st_r_q, st_r_d;
  logic [RW-1:0]        rl_l_q, rl_l_d, rl_r_q, rl_r_d;

  // working registers
  logic [GW-1:0]                      inner_l_q, inner_l_d, inner_r_q, inner_r_d;
  logic [GW-1:0]                      tgt_l_q, tgt_l_d, tgt_r_q, tgt_r_d;
  logic [EW-1:0]                      eff_l_q, eff_l_d, eff_r_q, eff_r_d;
  logic [SW-1:0]                      res_l_q, res_l_d, res_r_q, res_r_d;
  logic [SW-1:0]                      left_out_q, right_out_q;
  logic signed [msplm_pkg::PROD_W-1:0] prod_q;
  logic signed [19:0]                 ni_q;
  msplm_pkg::mul_op_e                 tag_q;

  // position and law operands
  logic [PW-1:0] p_sel, p_left;
  assign p_sel  = auto_q ? msplm_pkg::clamp_pos(apos_q) : pan_q;
  assign p_left = PW'(msplm_pkg::ONE_Q16) - p_sel;

  // ramp next value, from linear value plus step
  logic signed [19:0] ni_l, ni_r, dl, dr;
  assign ni_l = {3'b000, iv_l_q} + {{2{st_l_q[TW-1]}}, st_l_q};
  assign ni_r = {3'b000, iv_r_q} + {{2{st_r_q[TW-1]}}, st_r_q};
  assign dl   = {3'b000, g_l_q} - ni_l;
  assign dr   = {3'b000, g_r_q} - ni_r;

  // effective gain at the output: law gain direct in automated mode
  logic [EW-1:0] eff_use_l, eff_use_r;
  assign eff_use_l = auto_q ? {2'b00, tgt_l_q} : eff_l_q;
  assign eff_use_r = auto_q ? {2'b00, tgt_r_q} : eff_r_q;

  // shared multiplier operand select
  logic signed [msplm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [msplm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [19:0]                   ni_sel;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    ni_sel = ni_l;
    case (cmd_i.op)
      msplm_pkg::OP_LAW1_L: begin
        mul_a = {8'd0, p_sel};
        mul_b = msplm_pkg::MUL_B_W'(msplm_pkg::LAW_A);
      end
      msplm_pkg::OP_LAW1_R: begin
        mul_a = {8'd0, p_left};
        mul_b = msplm_pkg::MUL_B_W'(msplm_pkg::LAW_A);
      end
      msplm_pkg::OP_LAW2_L: begin
        mul_a = {8'd0, p_left};
        mul_b = {4'd0, inner_l_q};
      end
      msplm_pkg::OP_LAW2_R: begin
        mul_a = {8'd0, p_sel};
        mul_b = {4'd0, inner_r_q};
      end
      msplm_pkg::OP_ADV_L: begin
        mul_a  = {{5{dl[19]}}, dl};
        mul_b  = msplm_pkg::MUL_B_W'(msplm_pkg::SMOOTH_Q16);
        ni_sel = ni_l;
      end
      msplm_pkg::OP_ADV_R: begin
        mul_a  = {{5{dr[19]}}, dr};
        mul_b  = msplm_pkg::MUL_B_W'(msplm_pkg::SMOOTH_Q16);
        ni_sel = ni_r;
      end
      msplm_pkg::OP_EFF_L: begin
        mul_a = {7'd0, coeff_q};
        mul_b = {4'd0, g_l_q};
      end
      msplm_pkg::OP_EFF_R: begin
        mul_a = {7'd0, coeff_q};
        mul_b = {4'd0, g_r_q};
      end
      msplm_pkg::OP_OUT_L: begin
        mul_a = {smp_q[SW-1], smp_q};
        mul_b = {2'b00, eff_use_l};
      end
      msplm_pkg::OP_OUT_R: begin
        mul_a = {smp_q[SW-1], smp_q};
        mul_b = {2'b00, eff_use_r};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= msplm_pkg::OP_NONE;
    end else begin
      tag_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    ni_q   <= ni_sel;
  end

  // ramp step divider, shared by both channels
  logic signed [TW-1:0] div_num, quot;
  logic [RW-1:0]        lim;
  logic                 div_busy;

  assign div_num = cmd_i.div_sel ? ({1'b0, tgt_r_q} - {1'b0, g_r_q})
                                 : ({1'b0, tgt_l_q} - {1'b0, g_l_q});

  always_comb begin
    if (frames_q == '0) begin
      lim = RW'(1);
    end else if (frames_q < msplm_pkg::FRAMES_W'(msplm_pkg::RAMP_LEN)) begin
      lim = frames_q[RW-1:0];
    end else begin
      lim = RW'(msplm_pkg::RAMP_LEN);
    end
  end

  msplm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (lim),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // threshold test at block start
  logic signed [TW-1:0] dd_l, dd_r;
  logic                 far_l, far_r;
  assign dd_l  = {1'b0, g_l_q} - {1'b0, tgt_l_q};
  assign dd_r  = {1'b0, g_r_q} - {1'b0, tgt_r_q};
  assign far_l = (dd_l > $signed(TW'(msplm_pkg::THRESH)))
              || (dd_l < -$signed(TW'(msplm_pkg::THRESH)));
  assign far_r = (dd_r > $signed(TW'(msplm_pkg::THRESH)))
              || (dd_r < -$signed(TW'(msplm_pkg::THRESH)));

  // write-back of the op that sits in the product register
  logic signed [msplm_pkg::RND_W-1:0] rp;
  logic signed [21:0]                 ng;
  logic signed [30:0]                 sum_l, sum_r;

  assign rp    = msplm_pkg::rnd16(prod_q);
  assign ng    = {{2{ni_q[19]}}, ni_q} + rp[21:0];
  assign sum_l = {{7{lmix_q[SW-1]}}, lmix_q} + {rp[msplm_pkg::RND_W-1], rp};
  assign sum_r = {{7{rmix_q[SW-1]}}, rmix_q} + {rp[msplm_pkg::RND_W-1], rp};

  always_comb begin
    g_l_d     = g_l_q;
    iv_l_d    = iv_l_q;
    st_l_d    = st_l_q;
    rl_l_d    = rl_l_q;
    g_r_d     = g_r_q;
    iv_r_d    = iv_r_q;
    st_r_d    = st_r_q;
    rl_r_d    = rl_r_q;
    inner_l_d = inner_l_q;
    inner_r_d = inner_r_q;
    tgt_l_d   = tgt_l_q;
    tgt_r_d   = tgt_r_q;
    eff_l_d   = eff_l_q;
    eff_r_d   = eff_r_q;
    res_l_d   = res_l_q;
    res_r_d   = res_r_q;
    case (tag_q)
      msplm_pkg::OP_LAW1_L: inner_l_d = GW'(msplm_pkg::ONE_Q16) + rp[GW-1:0];
      msplm_pkg::OP_LAW1_R: inner_r_d = GW'(msplm_pkg::ONE_Q16) + rp[GW-1:0];
      msplm_pkg::OP_LAW2_L: tgt_l_d = rp[GW-1:0];
      msplm_pkg::OP_LAW2_R: tgt_r_d = rp[GW-1:0];
      msplm_pkg::OP_ADV_L: begin
        if (rl_l_q != '0) begin
          iv_l_d = msplm_pkg::clamp_gain({{2{ni_q[19]}}, ni_q});
          g_l_d  = msplm_pkg::clamp_gain(ng);
          rl_l_d = rl_l_q - RW'(1);
        end
      end
      msplm_pkg::OP_ADV_R: begin
        if (rl_r_q != '0) begin
          iv_r_d = msplm_pkg::clamp_gain({{2{ni_q[19]}}, ni_q});
          g_r_d  = msplm_pkg::clamp_gain(ng);
          rl_r_d = rl_r_q - RW'(1);
        end
      end
      msplm_pkg::OP_EFF_L: eff_l_d = rp[EW-1:0];
      msplm_pkg::OP_EFF_R: eff_r_d = rp[EW-1:0];
      msplm_pkg::OP_OUT_L: res_l_d = msplm_pkg::sat_sample(sum_l);
      msplm_pkg::OP_OUT_R: res_r_d = msplm_pkg::sat_sample(sum_r);
      default: begin
        res_l_d = res_l_q;
      end
    endcase
    // block start: ramp toward target or snap onto it
    if (cmd_i.blk_l) begin
      if (far_l) begin
        st_l_d = quot;
        rl_l_d = lim;
      end else begin
        g_l_d  = tgt_l_q;
        iv_l_d = tgt_l_q;
        st_l_d = '0;
        rl_l_d = '0;
      end
    end
    if (cmd_i.blk_r) begin
      if (far_r) begin
        st_r_d = quot;
        rl_r_d = lim;
      end else begin
        g_r_d  = tgt_r_q;
        iv_r_d = tgt_r_q;
        st_r_d = '0;
        rl_r_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_l_q  <= GW'(msplm_pkg::CENTER_GAIN);
      iv_l_q <= GW'(msplm_pkg::CENTER_GAIN);
      st_l_q <= '0;
      rl_l_q <= '0;
      g_r_q  <= GW'(msplm_pkg::CENTER_GAIN);
      iv_r_q <= GW'(msplm_pkg::CENTER_GAIN);
      st_r_q <= '0;
      rl_r_q <= '0;
    end else begin
      g_l_q  <= g_l_d;
      iv_l_q <= iv_l_d;
      st_l_q <= st_l_d;
      rl_l_q <= rl_l_d;
      g_r_q  <= g_r_d;
      iv_r_q <= iv_r_d;
      st_r_q <= st_r_d;
      rl_r_q <= rl_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inner_l_q <= inner_l_d;
    inner_r_q <= inner_r_d;
    tgt_l_q   <= tgt_l_d;
    tgt_r_q   <= tgt_r_d;
    eff_l_q   <= eff_l_d;
    eff_r_q   <= eff_r_d;
    res_l_q   <= res_l_d;
    res_r_q   <= res_r_d;
    if (cmd_i.load_out) begin
      left_out_q  <= res_l_q;
      right_out_q <= res_r_q;
    end
  end

  assign status_o.auto_mode   = auto_q;
  assign status_o.block_start = blk_q;
  assign status_o.div_busy    = div_busy;

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

[rtl/mono_stereo_pan_law_mixer.sv]
// top level of the mono to stereo pan-law mixer
// depends on msplm_pkg, msplm_ctrl, msplm_dpath (and msplm_div below it)
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one mono sample, the left
//   and right mix values, block markers, master gain and automation position
//   per transaction. output channel (out_valid_o / out_stall_i) carries the
//   left and right mixed results, one output transaction per input. config port:
//   cfg_we_i writes cfg_wdata_i into register cfg_index_i (0 pan position, 1
//   automation mode); the user writes only while the block is idle, unenforced.
// timing:
//   one item at a time; a shared 25x21 multiplier takes one op per cycle
//   and the step divider yields one quotient bit per cycle.
//   manual sample, no block start: ramp-advance, effective-gain and output ops.
//   automated mode: four law ops, then two output ops.
//   manual block start: law ops and the left then the right step divide first.
//   the next item is taken in the cycle after the result loads.
// reset: gains go to center (46396), ramps stop, pan 32768, manual mode.
// stall: the output reg holds its result while out_stall_i is high; a new item
//   may be accepted and worked on meanwhile, finishing only when the slot frees.
module mono_stereo_pan_law_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [msplm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msplm_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0] left_mix_in_i,
  input  logic signed [msplm_pkg::SAMPLE_W-1:0] right_mix_in_i,
  input  logic                                  block_start_i,
  input  logic [msplm_pkg::FRAMES_W-1:0]        block_frames_i,
  input  logic [msplm_pkg::COEFF_W-1:0]         gain_coeff_i,
  input  logic [msplm_pkg::POS_W-1:0]           automation_position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [msplm_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [msplm_pkg::SAMPLE_W-1:0] right_out_o
);

  // command and status between sequencer and datapath
  msplm_pkg::ctrl_cmd_t  cmd;
  msplm_pkg::dp_status_t status;

  msplm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msplm_dpath u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .sample_in_i           (sample_in_i),
    .left_mix_in_i         (left_mix_in_i),
    .right_mix_in_i        (right_mix_in_i),
    .block_start_i         (block_start_i),
    .block_frames_i        (block_frames_i),
    .gain_coeff_i          (gain_coeff_i),
    .automation_position_i (automation_position_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .left_out_o            (left_out_o),
    .right_out_o           (right_out_o)
  );

endmodule

[tb/testbench.sv]
// self-checking testbench for the mono to stereo pan-law mixer
// holds a pan-law predictor with its own gain ramps; depends on msplm_pkg and the dut
module testbench;

  localparam int CLK_HALF     = 10;
  localparam int DRAIN_CYCLES = 64;      // extra wait at the end of each drain
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RUN_LIMIT    = 40000000; // hard-stop time for the whole run

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  typedef struct {
    logic signed [23:0] sample;
    logic signed [23:0] left_mix;
    logic signed [23:0] right_mix;
    logic               block_start;
    logic [13:0]        frames;
    logic [17:0]        coeff;
    logic [16:0]        position;
  } mono_item_t;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
  } stereo_mix_t;

  // predicts left/right mixes and holds them until the dut delivers
  class pan_law_tracker;
    longint      pan_reg;
    bit          auto_reg;
    longint      gain[2];
    longint      ramp_val[2];
    longint      step[2];
    int          ramp_cnt[2];
    stereo_mix_t expected_mix_q[$];
    int unsigned error_count;

    function new();
      pan_reg  = msplm_pkg::POS_RESET;
      auto_reg = 1'b0;
      for (int c = 0; c < 2; c++) begin
        gain[c]     = msplm_pkg::CENTER_GAIN;
        ramp_val[c] = msplm_pkg::CENTER_GAIN;
        step[c]     = 0;
        ramp_cnt[c] = 0;
      end
      error_count = 0;
    endfunction

    function longint sat_position(longint p);
      return (p > msplm_pkg::ONE_Q16) ? longint'(msplm_pkg::ONE_Q16) : p;
    endfunction

    function void write_reg(logic [msplm_pkg::CFG_IDX_W-1:0] idx, logic [16:0] data);
      longint v;
      v = data;
      if (idx == msplm_pkg::REG_PAN_POSITION) begin
        pan_reg = sat_position(v);
      end else begin
        auto_reg = data[0];
      end
    endfunction

    // nearest, halves away from zero
    function longint round_q16(longint v);
      if (v >= 0) return (v + 32768) >>> 16;
      return -(((-v) + 32768) >>> 16);
    endfunction

    function longint pan_law_gain(longint p);
      longint q, inner;
      q     = msplm_pkg::ONE_Q16 - p;
      inner = msplm_pkg::ONE_Q16 + ((msplm_pkg::LAW_A * q + 32768) >>> 16);
      return (p * inner + 32768) >>> 16;
    endfunction

    function longint limit_gain(longint g);
      if (g < 0) return 0;
      if (g > msplm_pkg::GAIN_MAX) return msplm_pkg::GAIN_MAX;
      return g;
    endfunction

    function void start_block(int c, longint target, longint frames);
      longint diff, span;
      diff = gain[c] - target;
      if (diff > msplm_pkg::THRESH || diff < -msplm_pkg::THRESH) begin
        span = (frames < msplm_pkg::RAMP_LEN) ? frames : msplm_pkg::RAMP_LEN;
        if (span == 0) span = 1;
        step[c]     = (target - gain[c]) / span;
        ramp_cnt[c] = int'(span);
      end else begin
        gain[c]     = target;
        ramp_val[c] = target;
        step[c]     = 0;
        ramp_cnt[c] = 0;
      end
    endfunction

    function void advance_ramp(int c);
      longint nxt_ramp, nxt_gain;
      if (ramp_cnt[c] == 0) return;
      nxt_ramp    = ramp_val[c] + step[c];
      nxt_gain    = nxt_ramp + round_q16((gain[c] - nxt_ramp) * msplm_pkg::SMOOTH_Q16);
      ramp_val[c] = limit_gain(nxt_ramp);
      gain[c]     = limit_gain(nxt_gain);
      ramp_cnt[c]--;
    endfunction

    function logic [23:0] mix_sat(longint mix, longint smp, longint eff);
      longint r;
      r = mix + round_q16(smp * eff);
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return 24'(r);
    endfunction

    function void note_sample(mono_item_t it);
      longint      smp, lmix, rmix, coeff, frames, p, eff_l, eff_r;
      stereo_mix_t e;
      smp    = it.sample;
      lmix   = it.left_mix;
      rmix   = it.right_mix;
      coeff  = it.coeff;
      frames = it.frames;
      if (auto_reg) begin
        p     = it.position;
        p     = sat_position(p);
        eff_l = pan_law_gain(msplm_pkg::ONE_Q16 - p);
        eff_r = pan_law_gain(p);
      end else begin
        if (it.block_start) begin
          start_block(0, pan_law_gain(msplm_pkg::ONE_Q16 - pan_reg), frames);
          start_block(1, pan_law_gain(pan_reg), frames);
        end
        advance_ramp(0);
        advance_ramp(1);
        eff_l = (gain[0] * coeff + 32768) >>> 16;
        eff_r = (gain[1] * coeff + 32768) >>> 16;
      end
      e.left  = mix_sat(lmix, smp, eff_l);
      e.right = mix_sat(rmix, smp, eff_r);
      expected_mix_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    task check_mix(logic [23:0] l, logic [23:0] r);
      stereo_mix_t e;
      if (expected_mix_q.size() == 0) begin
        report_mismatch("output transaction with no pending expectation");
      end else begin
        e = expected_mix_q.pop_front();
        if (l !== e.left) begin
          report_mismatch($sformatf("left_out got %0d expected %0d", $signed(l),
                                    $signed(e.left)));
        end
        if (r !== e.right) begin
          report_mismatch($sformatf("right_out got %0d expected %0d", $signed(r),
                                    $signed(e.right)));
        end
      end
    endtask

    task report_leftovers();
      if (expected_mix_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected transactions never arrived",
                                  expected_mix_q.size()));
      end
    endtask

    function int pending();
      return expected_mix_q.size();
    endfunction
  endclass

  // clock, reset and dut ports
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [msplm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [msplm_pkg::CFG_W-1:0]     cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [23:0] sample_in_i;
  logic signed [23:0] left_mix_in_i;
  logic signed [23:0] right_mix_in_i;
  logic               block_start_i;
  logic [13:0]        block_frames_i;
  logic [17:0]        gain_coeff_i;
  logic [16:0]        automation_position_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [23:0] left_out_o;
  logic signed [23:0] right_out_o;

  pan_law_tracker tracker = new();

  // sender pacing and receiver stall pattern state
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  longint prev_pan = msplm_pkg::POS_RESET;

  mono_stereo_pan_law_mixer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .sample_in_i          (sample_in_i),
    .left_mix_in_i        (left_mix_in_i),
    .right_mix_in_i       (right_mix_in_i),
    .block_start_i        (block_start_i),
    .block_frames_i       (block_frames_i),
    .gain_coeff_i         (gain_coeff_i),
    .automation_position_i(automation_position_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .left_out_o           (left_out_o),
    .right_out_o          (right_out_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // receiver: picks a stall style for a random stretch, then another
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;                          // free-flowing stretch
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);   // light stalls
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);   // heavy stalls
      end
      default: begin
        out_stall_i <= ((stall_span % 16) < 6);       // regular long stalls
      end
    endcase
  end

  // output monitor: a transaction moves when valid is high and stall is low
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      tracker.check_mix(left_out_o, right_out_o);
    end
  end

  // hold one input transaction until the dut takes it
  task automatic send_item(input mono_item_t it);
    in_valid_i            <= 1'b1;
    sample_in_i           <= it.sample;
    left_mix_in_i         <= it.left_mix;
    right_mix_in_i        <= it.right_mix;
    block_start_i         <= it.block_start;
    block_frames_i        <= it.frames;
    gain_coeff_i          <= it.coeff;
    automation_position_i <= it.position;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_sample(it);
  endtask

  // bursts of random length with random gaps, some long gapless stretches
  task automatic send_paced(input mono_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    send_item(it);
  endtask

  // stop sending and wait until every expected transaction has come back
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // the last clock wait keeps back-to-back writes from stacking two updates of cfg_we_i
  task automatic write_cfg(input logic [msplm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [16:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic mono_item_t make_item(logic signed [23:0] smp, logic signed [23:0] lm,
                                           logic signed [23:0] rm, logic start,
                                           logic [13:0] frames, logic [17:0] coeff,
                                           logic [16:0] pos);
    mono_item_t it;
    it.sample      = smp;
    it.left_mix    = lm;
    it.right_mix   = rm;
    it.block_start = start;
    it.frames      = frames;
    it.coeff       = coeff;
    it.position    = pos;
    return it;
  endfunction

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return 24'($signed($urandom_range(0, 512)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [17:0] pick_coeff();
    case ($urandom_range(0, 7))
      0:       return 18'd0;
      1:       return 18'd131072;
      2:       return 18'd65536;
      default: return 18'($urandom_range(0, 131072));
    endcase
  endfunction

  // includes positions past full scale
  function automatic logic [16:0] pick_position();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // mostly short blocks, a zero length now and then, a few long ones
  function automatic logic [13:0] pick_frames();
    case ($urandom_range(0, 9))
      0:       return 14'd0;
      1:       return 14'd8192;
      2:       return 14'($urandom_range(1, 8192));
      default: return 14'($urandom_range(1, 80));
    endcase
  endfunction

  function automatic mono_item_t random_item(logic start, logic [13:0] frames);
    return make_item(pick_sample(), pick_sample(), pick_sample(), start, frames,
                     pick_coeff(), pick_position());
  endfunction

  function automatic logic [16:0] pick_pan();
    longint p;
    case ($urandom_range(0, 7))
      0: p = 0;
      1: p = 65536;
      2: p = $urandom_range(65537, 131071);
      3: p = 32768;
      4: begin
        // small move, so gains land within the snap threshold
        p = prev_pan + $signed($urandom_range(0, 80)) - 40;
        if (p < 0) p = 0;
        if (p > 131071) p = 131071;
      end
      default: p = $urandom_range(0, 131071);
    endcase
    prev_pan = (p > 65536) ? 65536 : p;
    return 17'(p);
  endfunction

  // hard stop if the dut hangs
  initial begin
    #(RUN_LIMIT);
    $display("mono_stereo_pan_law_mixer test failed");
    $finish;
  end

  initial begin
    int         count, run;
    logic [13:0] frames;

    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= msplm_pkg::REG_PAN_POSITION;
    cfg_wdata_i           <= '0;
    in_valid_i            <= 1'b0;
    sample_in_i           <= '0;
    left_mix_in_i         <= '0;
    right_mix_in_i        <= '0;
    block_start_i         <= 1'b0;
    block_frames_i        <= 14'd1;
    gain_coeff_i          <= '0;
    automation_position_i <= '0;
    out_stall_i           <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains, sample and mix extremes, saturation both ways
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd65536, 17'd0));
    send_paced(make_item(S_MIN, S_MAX, S_MIN, 1'b0, 14'd1, 18'd131072, 17'd65536));
    send_paced(make_item(S_MAX, S_MAX, S_MAX, 1'b0, 14'd1, 18'd131072, 17'd0));
    send_paced(make_item(S_MIN, S_MIN, S_MIN, 1'b0, 14'd1, 18'd131072, 17'd0));
    send_paced(make_item(24'sd1000, -24'sd5, 24'sd7, 1'b0, 14'd1, 18'd0, 17'd0));
    send_paced(make_item(-24'sd1, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd65536, 17'd0));

    // hard left, zero block length ramps over a single sample
    settle();
    write_cfg(msplm_pkg::REG_PAN_POSITION, 17'd0);
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b1, 14'd0, 18'd65536, 17'd0));
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd65536, 17'd0));

    // hard right, long block ramps over the full ramp length, then a new
    // block start lands in the middle of the ramp
    settle();
    write_cfg(msplm_pkg::REG_PAN_POSITION, 17'd65536);
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b1, 14'd8192, 18'd65536, 17'd0));
    repeat (5) send_paced(random_item(1'b0, 14'd1));
    send_paced(make_item(S_MIN, 24'sd0, 24'sd0, 1'b1, 14'd20, 18'd65536, 17'd0));
    repeat (2) send_paced(random_item(1'b0, 14'd1));

    // automated mode freezes the ramp; block start is ignored here
    settle();
    write_cfg(msplm_pkg::REG_AUTOMATION, 17'd1);
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd0, 17'd0));
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd0, 17'd65536));
    send_paced(make_item(S_MIN, 24'sd0, 24'sd0, 1'b1, 14'd3, 18'd0, 17'd131071));
    send_paced(make_item(S_MAX, S_MAX, S_MIN, 1'b0, 14'd1, 18'd131072, 17'd32768));

    // back to manual: the frozen ramp resumes
    settle();
    write_cfg(msplm_pkg::REG_AUTOMATION, 17'd0);
    repeat (2) send_paced(random_item(1'b0, 14'd1));

    // register position past full scale saturates
    settle();
    write_cfg(msplm_pkg::REG_PAN_POSITION, 17'd131071);
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b1, 14'd5, 18'd65536, 17'd0));
    send_paced(make_item(S_MAX, 24'sd0, 24'sd0, 1'b0, 14'd1, 18'd65536, 17'd0));
    prev_pan = 65536;

    // random phases: mostly well-formed blocks, some noise and cut-short blocks
    for (int phase = 0; phase < 18; phase++) begin
      settle();
      write_cfg(msplm_pkg::REG_PAN_POSITION, pick_pan());
      write_cfg(msplm_pkg::REG_AUTOMATION, 17'($urandom_range(0, 3) == 0));
      count = 0;
      while (count < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          send_paced(random_item(1'($urandom_range(0, 1)), pick_frames()));
          count++;
        end else begin
          frames = pick_frames();
          run = (frames == 0) ? 1 : int'(frames);
          if (run > 100) run = $urandom_range(1, 100);
          for (int k = 0; k < run && count < 100; k++) begin
            send_paced(random_item(k == 0, frames));
            count++;
          end
        end
      end
    end

    // drain, then judge
    settle();
    tracker.report_leftovers();
    if (tracker.error_count == 0) begin
      $display("mono_stereo_pan_law_mixer test passed");
    end else begin
      $display("mono_stereo_pan_law_mixer test failed");
    end
    $finish;
  end

endmodule

[mono_stereo_pan_law_mixer.f]
rtl/msplm_pkg.sv
rtl/msplm_div.sv
rtl/msplm_ctrl.sv
rtl/msplm_dpath.sv
rtl/mono_stereo_pan_law_mixer.sv
tb/testbench.sv
